// File: design/iirbs_pkg.sv
package iirbs_pkg;

	localparam int CHANNELS_DEF    = 2;
	localparam int SAMPLE_BITS_DEF = 32;

	localparam int TAPS      = 10;
	localparam int FB_TERMS  = 5;
	localparam int TAP_W     = $clog2(FB_TERMS);
	localparam int COEF_W    = 35;
	localparam int HALF_W    = 32;
	localparam int OPD_W     = HALF_W + 1;
	localparam int PROD_W    = COEF_W + OPD_W;
	localparam int ACC_W     = 104;
	localparam int Y_W       = 64;
	localparam int X_GROWTH  = 7;
	localparam int FF_GROWTH = 5;
	localparam int X_SHIFT   = 24;
	localparam int Y_SHIFT   = 30;
	localparam int OUT_SHIFT = 24;

	localparam logic signed [COEF_W-1:0] INV_GAIN = 35'sd1087328963;

	typedef struct packed {
		logic clr;
		logic load;
		logic issue;
		logic hi;
	} mac_ctl_t;

	// coefficient k weights y[n-10+2k]
	function automatic logic signed [COEF_W-1:0] fb_coef(input logic [TAP_W-1:0] k);
		logic signed [COEF_W-1:0] c;
		case (k)
			3'd0:    c = 35'sd609851893;
			3'd1:    c = -35'sd3393577687;
			3'd2:    c = 35'sd7574986232;
			3'd3:    c = -35'sd8480133146;
			3'd4:    c = 35'sd4762481802;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

// File: design/iirbs_mac.sv
module iirbs_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  iirbs_pkg::mac_ctl_t                   ctl,
	input  logic signed [iirbs_pkg::COEF_W-1:0]   coef,
	input  logic signed [iirbs_pkg::OPD_W-1:0]    opd,
	input  logic signed [iirbs_pkg::ACC_W-1:0]    load_val,
	output logic signed [iirbs_pkg::ACC_W-1:0]    acc
);
	import iirbs_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;
	logic                     vld_s1;
	logic                     hi_s1;
	logic signed [ACC_W-1:0]  addend;
	logic signed [ACC_W-1:0]  acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			hi_s1  <= 1'b0;
		end else begin
			vld_s1 <= ctl.issue;
			hi_s1  <= ctl.hi;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(coef) * PROD_W'(opd);
	end

	always_comb begin
		addend = hi_s1 ? (ACC_W'(prod_s1) <<< HALF_W) : ACC_W'(prod_s1);
	end

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.load) begin
			acc_q <= load_val;
		end else if (vld_s1) begin
			acc_q <= acc_q + addend;
		end
	end

	assign acc = acc_q;

endmodule

// File: design/iirbs_hist.sv
module iirbs_hist #(
	parameter int CHANNELS = iirbs_pkg::CHANNELS_DEF,
	parameter int XW       = iirbs_pkg::SAMPLE_BITS_DEF + iirbs_pkg::X_GROWTH
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    push,
	input  logic signed [XW-1:0]                    x_new,
	input  logic signed [iirbs_pkg::Y_W-1:0]        y_new,
	input  logic signed [XW-1:0]                    x_cur,
	input  logic [iirbs_pkg::TAP_W-1:0]             tap,
	output logic signed [XW+iirbs_pkg::FF_GROWTH-1:0] ff,
	output logic signed [iirbs_pkg::Y_W-1:0]        y_tap
);
	import iirbs_pkg::*;

	localparam int FFW = XW + FF_GROWTH;

	logic signed [XW-1:0]  xh_q [CHANNELS][TAPS];
	logic signed [Y_W-1:0] yh_q [CHANNELS][TAPS];
	logic signed [FFW-1:0] s17;
	logic signed [FFW-1:0] s35;

	// channel in work always sits in row 0; rotate rows on each push
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				for (int t = 0; t < TAPS; t++) begin
					xh_q[c][t] <= '0;
					yh_q[c][t] <= '0;
				end
			end
		end else if (push) begin
			for (int c = 0; c < CHANNELS - 1; c++) begin
				xh_q[c] <= xh_q[c+1];
				yh_q[c] <= yh_q[c+1];
			end
			xh_q[CHANNELS-1][0] <= x_new;
			yh_q[CHANNELS-1][0] <= y_new;
			for (int t = 1; t < TAPS; t++) begin
				xh_q[CHANNELS-1][t] <= xh_q[0][t-1];
				yh_q[CHANNELS-1][t] <= yh_q[0][t-1];
			end
		end
	end

	always_comb begin
		s17 = FFW'(xh_q[0][1]) + FFW'(xh_q[0][7]);
		s35 = FFW'(xh_q[0][3]) + FFW'(xh_q[0][5]);
		ff  = FFW'(x_cur) + FFW'(xh_q[0][9]) + (s17 <<< 2) + s17 + (s35 <<< 3) + (s35 <<< 1);
	end

	always_comb begin
		case (tap)
			3'd0:    y_tap = yh_q[0][9];
			3'd1:    y_tap = yh_q[0][7];
			3'd2:    y_tap = yh_q[0][5];
			3'd3:    y_tap = yh_q[0][3];
			3'd4:    y_tap = yh_q[0][1];
			default: y_tap = '0;
		endcase
	end

endmodule

// File: design/iir_bandstop_two_channel.sv
// Tenth-order bandstop filter, notch at a quarter of the sample rate, on
// CHANNELS Q16.16 samples per request, plus one component copied unchanged.
// Input channel s_*: s_tdata carries one sample per channel, then the
// passthrough component, each SAMPLE_BITS wide, lowest field first.
// Output channel m_*: m_tdata carries one filtered sample per channel, then
// the passthrough copy, in the same layout.
// One multiplier (35 x 33 bits, registered) and one accumulator do all the
// work: per channel two products for the input scaling and ten for the
// feedback taps. s_tready is low from acceptance until the result has
// moved to the output register, so a new request is taken only after the
// previous one is finished.
// Reset clears the input and output histories of every channel and drops
// m_tvalid. A stalled receiver holds m_tvalid and m_tdata; the block still
// accepts one more request meanwhile and holds its finished result until
// the output register is free.
module iir_bandstop_two_channel #(
	parameter int CHANNELS    = iirbs_pkg::CHANNELS_DEF,
	parameter int SAMPLE_BITS = iirbs_pkg::SAMPLE_BITS_DEF,
	localparam int DATA_W     = ((CHANNELS + 1) * SAMPLE_BITS + 7) / 8 * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,  // sample per channel (a, b, ...), passthrough_in
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata   // filtered per channel (a, b, ...), passthrough_out
);
	import iirbs_pkg::*;

	localparam int SB   = SAMPLE_BITS;
	localparam int XW   = SAMPLE_BITS + X_GROWTH;
	localparam int FFW  = XW + FF_GROWTH;
	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int OP_W = 4;
	localparam int RW   = Y_W + 1;

	localparam logic [CH_W-1:0] CH_LAST       = CH_W'(CHANNELS - 1);
	localparam logic [OP_W-1:0] OP_LAST_SCALE = OP_W'(1);
	localparam logic [OP_W-1:0] OP_LAST_FB    = OP_W'(2 * FB_TERMS - 1);

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_SCALE     = 4'd1;
	localparam logic [3:0] ST_SCALE_END = 4'd2;
	localparam logic [3:0] ST_X         = 4'd3;
	localparam logic [3:0] ST_FF        = 4'd4;
	localparam logic [3:0] ST_FB        = 4'd5;
	localparam logic [3:0] ST_FB_END    = 4'd6;
	localparam logic [3:0] ST_Y         = 4'd7;
	localparam logic [3:0] ST_WB        = 4'd8;
	localparam logic [3:0] ST_DONE      = 4'd9;

	logic [3:0]             state_q;
	logic [OP_W-1:0]        op_q;
	logic [CH_W-1:0]        ch_q;
	logic signed [SB-1:0]   smp_q [CHANNELS];
	logic signed [SB-1:0]   res_q [CHANNELS];
	logic [SB-1:0]          pt_q;
	logic signed [XW-1:0]   x_q;
	logic signed [Y_W-1:0]  y_q;
	logic [DATA_W-1:0]      m_data_q;
	logic                   m_valid_q;

	logic                   accept;
	logic                   out_load;
	mac_ctl_t               mac_ctl;
	logic signed [COEF_W-1:0] coef;
	logic signed [Y_W-1:0]  opd_word;
	logic signed [OPD_W-1:0] opd;
	logic signed [ACC_W-1:0] load_val;
	logic signed [ACC_W-1:0] acc;
	logic signed [FFW-1:0]  ff;
	logic signed [Y_W-1:0]  y_tap;
	logic [TAP_W-1:0]       tap;
	logic signed [ACC_W-1:0] x_rnd;
	logic signed [ACC_W-1:0] y_rnd;
	logic signed [Y_W-1:0]  y_sat;
	logic signed [RW-1:0]   out_rnd;
	logic signed [SB-1:0]   out_sat;
	logic [DATA_W-1:0]      out_word;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_tready);
	assign tap      = op_q[OP_W-1:1];

	always_comb begin
		mac_ctl  = '0;
		coef     = INV_GAIN;
		opd_word = {{(Y_W - SB){smp_q[0][SB-1]}}, smp_q[0]};
		case (state_q)
			ST_IDLE: begin
				mac_ctl.clr = accept;
			end
			ST_SCALE: begin
				mac_ctl.issue = 1'b1;
				mac_ctl.hi    = op_q[0];
			end
			ST_FF: begin
				mac_ctl.load  = 1'b1;
				mac_ctl.issue = 1'b1;
				mac_ctl.hi    = op_q[0];
				coef          = fb_coef(tap);
				opd_word      = y_tap;
			end
			ST_FB: begin
				mac_ctl.issue = 1'b1;
				mac_ctl.hi    = op_q[0];
				coef          = fb_coef(tap);
				opd_word      = y_tap;
			end
			ST_WB: begin
				mac_ctl.clr = (ch_q != CH_LAST);
			end
			default: begin
			end
		endcase
		opd = op_q[0] ? {opd_word[Y_W-1], opd_word[Y_W-1 -: HALF_W]}
		              : {1'b0, opd_word[HALF_W-1:0]};
	end

	assign load_val = ACC_W'(ff) <<< Y_SHIFT;

	iirbs_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mac_ctl),
		.coef     (coef),
		.opd      (opd),
		.load_val (load_val),
		.acc      (acc)
	);

	iirbs_hist #(
		.CHANNELS (CHANNELS),
		.XW       (XW)
	) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (state_q == ST_WB),
		.x_new  (x_q),
		.y_new  (y_q),
		.x_cur  (x_q),
		.tap    (tap),
		.ff     (ff),
		.y_tap  (y_tap)
	);

	always_comb begin
		x_rnd = acc + (ACC_W'(1) <<< (X_SHIFT - 1));
		y_rnd = acc + (ACC_W'(1) <<< (Y_SHIFT - 1));
		if ((&y_rnd[ACC_W-1:Y_SHIFT+Y_W-1]) || !(|y_rnd[ACC_W-1:Y_SHIFT+Y_W-1])) begin
			y_sat = y_rnd[Y_SHIFT +: Y_W];
		end else if (y_rnd[ACC_W-1]) begin
			y_sat = {1'b1, {(Y_W - 1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(Y_W - 1){1'b1}}};
		end
		out_rnd = {{(RW - Y_W + OUT_SHIFT){y_q[Y_W-1]}}, y_q[Y_W-1:OUT_SHIFT]}
		        + RW'(y_q[OUT_SHIFT-1]);
		if ((&out_rnd[RW-1:SB-1]) || !(|out_rnd[RW-1:SB-1])) begin
			out_sat = out_rnd[SB-1:0];
		end else if (out_rnd[RW-1]) begin
			out_sat = {1'b1, {(SB - 1){1'b0}}};
		end else begin
			out_sat = {1'b0, {(SB - 1){1'b1}}};
		end
	end

	always_comb begin
		out_word = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			out_word[c*SB +: SB] = res_q[c];
		end
		out_word[CHANNELS*SB +: SB] = pt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			op_q      <= '0;
			ch_q      <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q    <= '0;
						ch_q    <= '0;
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					if (op_q == OP_LAST_SCALE) begin
						state_q <= ST_SCALE_END;
					end
					op_q <= op_q + OP_W'(1);
				end
				ST_SCALE_END: begin
					state_q <= ST_X;
				end
				ST_X: begin
					op_q    <= '0;
					state_q <= ST_FF;
				end
				ST_FF: begin
					op_q    <= op_q + OP_W'(1);
					state_q <= ST_FB;
				end
				ST_FB: begin
					if (op_q == OP_LAST_FB) begin
						state_q <= ST_FB_END;
					end
					op_q <= op_q + OP_W'(1);
				end
				ST_FB_END: begin
					state_q <= ST_Y;
				end
				ST_Y: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (ch_q == CH_LAST) begin
						state_q <= ST_DONE;
					end else begin
						ch_q    <= ch_q + CH_W'(1);
						op_q    <= '0;
						state_q <= ST_SCALE;
					end
				end
				ST_DONE: begin
					if (!m_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int c = 0; c < CHANNELS; c++) begin
				smp_q[c] <= s_tdata[c*SB +: SB];
			end
			pt_q <= s_tdata[CHANNELS*SB +: SB];
		end
		if (state_q == ST_X) begin
			x_q <= x_rnd[X_SHIFT +: XW];
		end
		if (state_q == ST_Y) begin
			y_q <= y_sat;
		end
		if (state_q == ST_WB) begin
			for (int c = 0; c < CHANNELS - 1; c++) begin
				smp_q[c] <= smp_q[c+1];
				res_q[c] <= res_q[c+1];
			end
			smp_q[CHANNELS-1] <= smp_q[0];
			res_q[CHANNELS-1] <= out_sat;
		end
		if (out_load) begin
			m_data_q <= out_word;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

// File: design/iirbs_chk.sv
module iirbs_chk #(
	parameter int DATA_W = 96
) (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic [DATA_W-1:0] s_tdata,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DATA_W-1:0] m_tdata
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or dropped while stalled");

	// stay busy through the first channel
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##17 !s_tready)
		else $error("request taken before previous one finished");

	// drop ready only after a request
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid))
		else $error("ready dropped without a request");

	// raise a result only at the end of work
	a_result_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result raised while idle");

	logic unused_data;
	assign unused_data = ^s_tdata;

endmodule

bind iir_bandstop_two_channel iirbs_chk #(
	.DATA_W (DATA_W)
) u_iirbs_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
